// ----- rtl/mm_pkg.sv -----
// Shared constants, codes and types for the matrix multiply block.
package mm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed port widths
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Action codes of an input transfer
    localparam logic [ACT_W-1:0] ACT_LOAD_A = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_R = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Tag that travels alongside each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // Pipeline status seen by the sequencer
    typedef struct packed {
        logic adv;
        logic busy;
    } t_pipe_stat;

endpackage

// ----- rtl/mm_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read data.
module mm_ram #(
    parameter int DEPTH = mm_pkg::MAX_DIM_DEF * mm_pkg::MAX_DIM_DEF,
    parameter int WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mm_seq.sv -----
// Sequencer: configuration registers, load writes and the i/j/k address walk.
module mm_seq #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic [mm_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]                i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [mm_pkg::ACT_W-1:0]                i_action,
    input  logic [mm_pkg::IDX_W-1:0]                i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]                i_col_index,
    input  logic signed [mm_pkg::VAL_W-1:0]         i_element_value,
    input  mm_pkg::t_pipe_stat                      i_stat,
    output logic                                    o_we_a,
    output logic                                    o_we_b,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      o_waddr,
    output logic [DATA_WIDTH-1:0]                   o_wdata,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      o_raddr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      o_raddr_b,
    output mm_pkg::t_tag                            o_tag
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [mm_pkg::DIM_W-1:0] MAX_D = mm_pkg::DIM_W'(MAX_DIM);

    mm_pkg::t_seq_state r_state, n_state;

    logic [mm_pkg::DIM_W-1:0] r_rows, r_inner, r_cols;
    logic [mm_pkg::IDX_W-1:0] r_i, r_j, r_k;
    logic [mm_pkg::IDX_W-1:0] n_i, n_j, n_k;
    logic [mm_pkg::IDX_W-1:0] last_m, last_r, last_n;
    logic                     accept;
    logic                     start_acc;
    logic                     in_range;
    logic                     done;

    // Clamp a dimension into 1..MAX_DIM and return its last index
    function automatic logic [mm_pkg::IDX_W-1:0] last_idx(input logic [mm_pkg::DIM_W-1:0] d);
        logic [mm_pkg::DIM_W-1:0] e;
        e = d;
        if (d == '0) begin
            e = mm_pkg::DIM_W'(1);
        end else if (d > MAX_D) begin
            e = MAX_D;
        end
        return mm_pkg::IDX_W'(e - 1'b1);
    endfunction

    assign last_m = last_idx(r_rows);
    assign last_r = last_idx(r_inner);
    assign last_n = last_idx(r_cols);

    // Take new items only when idle and the pipeline has drained
    assign o_in_ready = (r_state == mm_pkg::SEQ_IDLE) && !i_stat.busy;
    assign accept     = i_in_valid && o_in_ready;
    assign start_acc  = accept && (i_action == mm_pkg::ACT_START);
    assign done       = (r_i == last_m) && (r_j == last_n) && (r_k == last_r);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mm_pkg::DIM_RESET;
            r_inner <= mm_pkg::DIM_RESET;
            r_cols  <= mm_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mm_pkg::CFG_ROWS_M:  r_rows  <= i_cfg_data;
                mm_pkg::CFG_INNER_R: r_inner <= i_cfg_data;
                mm_pkg::CFG_COLS_N:  r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load writes; drop loads outside the store
    assign in_range = ({1'b0, i_row_index} < MAX_D) && ({1'b0, i_col_index} < MAX_D);
    assign o_we_a   = accept && in_range && (i_action == mm_pkg::ACT_LOAD_A);
    assign o_we_b   = accept && in_range && (i_action == mm_pkg::ACT_LOAD_B);
    assign o_waddr  = ADDR_W'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign o_wdata  = i_element_value[DATA_WIDTH-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm_pkg::SEQ_IDLE: begin
                if (start_acc) begin
                    n_state = mm_pkg::SEQ_RUN;
                end
            end
            mm_pkg::SEQ_RUN: begin
                if (i_stat.adv && done) begin
                    n_state = mm_pkg::SEQ_IDLE;
                end
            end
            default: n_state = mm_pkg::SEQ_IDLE;
        endcase
    end

    // Advance k, then j, then i
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (start_acc) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (r_state == mm_pkg::SEQ_RUN && i_stat.adv) begin
            if (r_k != last_r) begin
                n_k = r_k + 1'b1;
            end else begin
                n_k = '0;
                if (r_j != last_n) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::SEQ_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Read addresses and step tag
    always_comb begin
        o_raddr_a       = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_k));
        o_raddr_b       = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_j));
        o_tag.valid     = (r_state == mm_pkg::SEQ_RUN);
        o_tag.first     = (r_k == '0);
        o_tag.last_k    = (r_k == last_r);
        o_tag.last_elem = (r_i == last_m) && (r_j == last_n);
        o_tag.row       = r_i;
        o_tag.col       = r_j;
    end

endmodule

// ----- rtl/mm_mac.sv -----
// Multiply-accumulate datapath: product, exact accumulation, shift, saturation, output register.
module mm_mac #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mm_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mm_pkg::t_tag                    i_tag,
    input  logic signed [DATA_WIDTH-1:0]    i_a,
    input  logic signed [DATA_WIDTH-1:0]    i_b,
    output mm_pkg::t_pipe_stat              o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mm_pkg::IDX_W-1:0]        o_out_row,
    output logic [mm_pkg::IDX_W-1:0]        o_out_col,
    output logic signed [mm_pkg::VAL_W-1:0] o_product_value,
    output logic                            o_last_element
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int HI_W   = ACC_W - DATA_WIDTH + 1;
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    mm_pkg::t_tag r_s1, r_s2, r_s3;

    logic                         adv;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      shifted;
    logic [HI_W-1:0]              hi_bits;
    logic                         overflow;
    logic signed [DATA_WIDTH-1:0] sat;
    logic                         emit;

    logic                         r_out_valid;
    logic [mm_pkg::IDX_W-1:0]     r_out_row;
    logic [mm_pkg::IDX_W-1:0]     r_out_col;
    logic signed [DATA_WIDTH-1:0] r_out_value;
    logic                         r_out_last;

    // Whole pipeline moves only when the output register can take a result
    assign adv         = !r_out_valid || i_out_ready;
    assign o_stat.adv  = adv;
    assign o_stat.busy = r_s1.valid || r_s2.valid || r_s3.valid;

    // Advance the tags with their data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (adv) begin
            r_s1 <= i_tag;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    // Accumulate at full width, restart on the first step of an element
    always_ff @(posedge i_clk) begin
        if (adv && r_s2.valid) begin
            if (r_s2.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Floor shift, then saturate
    always_comb begin
        shifted  = r_acc >>> FRAC_BITS;
        hi_bits  = shifted[ACC_W-1:DATA_WIDTH-1];
        overflow = !((&hi_bits) || !(|hi_bits));
        if (overflow) begin
            sat = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            sat = shifted[DATA_WIDTH-1:0];
        end
    end

    assign emit = r_s3.valid && r_s3.last_k;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out_row   <= r_s3.row;
            r_out_col   <= r_s3.col;
            r_out_value <= sat;
            r_out_last  <= r_s3.last_elem;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = mm_pkg::VAL_W'(r_out_value);
    assign o_last_element  = r_out_last;

endmodule

// ----- rtl/matrix_multiply.sv -----
// Top level of the matrix multiply block: C = A * B for matrices up to MAX_DIM square.
// After a start, the elements of C leave in row-major order, computed at one multiply-accumulate
// per cycle while the output register is not stalled; new transfers wait until the run has drained.
// Synchronous active-low reset clears control and sets the dimensions to 8;
// the element stores are not cleared and hold undefined data until loaded.
module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mm_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mm_pkg::ACT_W-1:0]        i_action,
    input  logic [mm_pkg::IDX_W-1:0]        i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]        i_col_index,
    input  logic signed [mm_pkg::VAL_W-1:0] i_element_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mm_pkg::IDX_W-1:0]        o_out_row,
    output logic [mm_pkg::IDX_W-1:0]        o_out_col,
    output logic signed [mm_pkg::VAL_W-1:0] o_product_value,
    output logic                            o_last_element
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    mm_pkg::t_tag       s_tag;
    mm_pkg::t_pipe_stat s_stat;

    logic                  we_a, we_b;
    logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    mm_seq #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .i_stat          (s_stat),
        .o_we_a          (we_a),
        .o_we_b          (we_b),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr_a       (raddr_a),
        .o_raddr_b       (raddr_b),
        .o_tag           (s_tag)
    );

    // Store of A
    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (s_stat.adv),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    // Store of B
    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (s_stat.adv),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    mm_mac #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tag           (s_tag),
        .i_a             (rdata_a),
        .i_b             (rdata_b),
        .o_stat          (s_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last_element  (o_last_element)
    );

`ifndef SYNTHESIS
    // No new transfer while the address walk is running
    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tag.valid |-> !o_in_ready)
        else $error("input ready while a run is in progress");

    // A start opens the walk at element (0,0), first step
    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == mm_pkg::ACT_START) |=>
        (s_tag.valid && s_tag.first && s_tag.row == '0 && s_tag.col == '0))
        else $error("start did not begin the walk at element zero");

    // The walk holds still while the output is stalled
    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tag.valid && !s_stat.adv) |=> $stable(s_tag))
        else $error("address walk moved during a stall");
`endif

endmodule

// ----- verif/matrix_multiply_test.sv -----
// Self-checking testbench for the matrix multiply block: predicts C = A * B from the input transfers.
module matrix_multiply_test;

    localparam logic [mm_pkg::ACT_W-1:0]     ACT_SPARE     = 2'd3;
    localparam logic [mm_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                           SETTLE_CYCLES = 16;
    localparam int                           HOLD_CYCLES   = 300;
    localparam int                           QUIET_LIMIT   = 4000;

    typedef struct {
        logic [mm_pkg::ACT_W-1:0] action;
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        logic [mm_pkg::VAL_W-1:0] value;
    } t_xfer;

    typedef struct {
        logic [mm_pkg::IDX_W-1:0] row;
        logic [mm_pkg::IDX_W-1:0] col;
        logic [mm_pkg::VAL_W-1:0] value;
        logic                     last;
    } t_c_elem;

    logic                             i_clk           = 1'b0;
    logic                             i_rst_n         = 1'b0;
    logic                             i_cfg_valid     = 1'b0;
    logic                             o_cfg_ready;
    logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index     = '0;
    logic [mm_pkg::DIM_W-1:0]         i_cfg_data      = '0;
    logic                             i_in_valid      = 1'b0;
    logic                             o_in_ready;
    logic [mm_pkg::ACT_W-1:0]         i_action        = '0;
    logic [mm_pkg::IDX_W-1:0]         i_row_index     = '0;
    logic [mm_pkg::IDX_W-1:0]         i_col_index     = '0;
    logic signed [mm_pkg::VAL_W-1:0]  i_element_value = '0;
    logic                             o_out_valid;
    logic                             i_out_ready     = 1'b0;
    logic [mm_pkg::IDX_W-1:0]         o_out_row;
    logic [mm_pkg::IDX_W-1:0]         o_out_col;
    logic signed [mm_pkg::VAL_W-1:0]  o_product_value;
    logic                             o_last_element;

    // Pending input transfers and the C elements still owed by the block
    t_xfer   pending_xfers[$];
    t_c_elem expected_c[$];
    t_xfer   next_xfer;
    t_c_elem want;

    // Predicted block state
    logic signed [mm_pkg::VAL_W-1:0] a_store[0:63];
    logic signed [mm_pkg::VAL_W-1:0] b_store[0:63];
    logic [mm_pkg::DIM_W-1:0]        dim_rows  = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]        dim_inner = mm_pkg::DIM_RESET;
    logic [mm_pkg::DIM_W-1:0]        dim_cols  = mm_pkg::DIM_RESET;

    // Stimulus-side view: which entries hold data, and the sizes in force
    bit a_loaded[0:63];
    bit b_loaded[0:63];
    int gen_m = 8;
    int gen_r = 8;
    int gen_n = 8;
    int item_count = 0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    int  quiet_cycles   = 0;
    int  errors         = 0;
    int  batch;
    bit  in_taken       = 1'b0;

    matrix_multiply u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last_element  (o_last_element)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Map a dimension register value to the size actually used
    function automatic int clamp_dim(input logic [mm_pkg::DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > mm_pkg::MAX_DIM_DEF)
            return mm_pkg::MAX_DIM_DEF;
        return int'(d);
    endfunction

    // Element values: saturating extremes, full random words, small Q16.16 numbers
    function automatic logic [mm_pkg::VAL_W-1:0] rand_elem();
        int pick;
        pick = $urandom_range(9, 0);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'(int'($urandom_range(1048575, 0)) - 524288);
        endcase
    endfunction

    // Update the predicted stores and work out the C elements of a start
    task automatic apply_transfer(input logic [mm_pkg::ACT_W-1:0] action,
                                  input logic [mm_pkg::IDX_W-1:0] row,
                                  input logic [mm_pkg::IDX_W-1:0] col,
                                  input logic [mm_pkg::VAL_W-1:0] value);
        int m, r, n, i, j, k;
        logic signed [71:0] acc, a_ext, b_ext, floored;
        t_c_elem elem;
        case (action)
            mm_pkg::ACT_LOAD_A: a_store[{row, col}] = value;
            mm_pkg::ACT_LOAD_B: b_store[{row, col}] = value;
            mm_pkg::ACT_START: begin
                m = clamp_dim(dim_rows);
                r = clamp_dim(dim_inner);
                n = clamp_dim(dim_cols);
                for (i = 0; i < m; i++) begin
                    for (j = 0; j < n; j++) begin
                        acc = '0;
                        for (k = 0; k < r; k++) begin
                            a_ext = a_store[i * 8 + k];
                            b_ext = b_store[k * 8 + j];
                            acc += a_ext * b_ext;
                        end
                        // Floor to the integer grid, then clip to the signed word range
                        floored = acc >>> mm_pkg::FRAC_BITS_DEF;
                        if (floored > 72'sh7FFF_FFFF)
                            floored = 72'sh7FFF_FFFF;
                        else if (floored < -72'sh8000_0000)
                            floored = -72'sh8000_0000;
                        elem.row   = 3'(i);
                        elem.col   = 3'(j);
                        elem.value = floored[mm_pkg::VAL_W-1:0];
                        elem.last  = (i == m - 1) && (j == n - 1);
                        expected_c.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Monitor: check results, track register and input transfers, watch for a hang
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_c.size() == 0) begin
                    $error("unexpected result: row %0d col %0d value %h", o_out_row, o_out_col,
                           o_product_value);
                    errors++;
                end else begin
                    want = expected_c.pop_front();
                    if (o_out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                        errors++;
                    end
                    if (o_out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                        errors++;
                    end
                    if (o_product_value !== want.value) begin
                        $error("product_value: expected %h, got %h", want.value, o_product_value);
                        errors++;
                    end
                    if (o_last_element !== want.last) begin
                        $error("last_element: expected %b, got %b", want.last, o_last_element);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mm_pkg::CFG_ROWS_M:  dim_rows  = i_cfg_data;
                    mm_pkg::CFG_INNER_R: dim_inner = i_cfg_data;
                    mm_pkg::CFG_COLS_N:  dim_cols  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                apply_transfer(i_action, i_row_index, i_col_index, i_element_value);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: offer the next pending transfer, or idle at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_xfers.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_xfer = pending_xfers.pop_front();
                i_in_valid      <= 1'b1;
                i_action        <= next_xfer.action;
                i_row_index     <= next_xfer.row;
                i_col_index     <= next_xfer.col;
                i_element_value <= next_xfer.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_out_ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Queue a transfer and note which store entries it fills
    task automatic queue_xfer(input logic [mm_pkg::ACT_W-1:0] action,
                              input logic [mm_pkg::IDX_W-1:0] row,
                              input logic [mm_pkg::IDX_W-1:0] col,
                              input logic [mm_pkg::VAL_W-1:0] value);
        t_xfer x;
        x.action = action;
        x.row    = row;
        x.col    = col;
        x.value  = value;
        pending_xfers.push_back(x);
        item_count++;
        if (action == mm_pkg::ACT_LOAD_A)
            a_loaded[{row, col}] = 1'b1;
        else if (action == mm_pkg::ACT_LOAD_B)
            b_loaded[{row, col}] = 1'b1;
    endtask

    // Fill every operand entry the next start will read but that holds no data yet
    task automatic load_missing_operands();
        int i, j, k;
        for (i = 0; i < gen_m; i++)
            for (k = 0; k < gen_r; k++)
                if (!a_loaded[i * 8 + k])
                    queue_xfer(mm_pkg::ACT_LOAD_A, 3'(i), 3'(k), rand_elem());
        for (k = 0; k < gen_r; k++)
            for (j = 0; j < gen_n; j++)
                if (!b_loaded[k * 8 + j])
                    queue_xfer(mm_pkg::ACT_LOAD_B, 3'(k), 3'(j), rand_elem());
    endtask

    // Wait until every transfer is taken and every result has arrived, then let the block settle
    task automatic wait_idle();
        while (pending_xfers.size() != 0 || i_in_valid || expected_c.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] index,
                             input logic [mm_pkg::DIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(input logic [mm_pkg::DIM_W-1:0] m, input logic [mm_pkg::DIM_W-1:0] r,
                            input logic [mm_pkg::DIM_W-1:0] n);
        wait_idle();
        write_reg(mm_pkg::CFG_ROWS_M, m);
        write_reg(mm_pkg::CFG_INNER_R, r);
        write_reg(mm_pkg::CFG_COLS_N, n);
        gen_m = clamp_dim(m);
        gen_r = clamp_dim(r);
        gen_n = clamp_dim(n);
    endtask

    // Mostly tiny sizes, now and then large or out-of-range codes
    function automatic logic [mm_pkg::DIM_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(19, 0);
        if (pick < 14)
            return 4'($urandom_range(3, 1));
        if (pick < 17)
            return 4'($urandom_range(8, 4));
        if (pick == 17)
            return 4'd0;
        return 4'($urandom_range(15, 9));
    endfunction

    // One well-formed run with scattered loads and noise around it
    task automatic run_batch(input bit with_hold);
        int n_loads, t;
        if (with_hold)
            hold_requests++;
        n_loads = $urandom_range(6, 0);
        for (t = 0; t < n_loads; t++)
            queue_xfer($urandom_range(1, 0) ? mm_pkg::ACT_LOAD_B : mm_pkg::ACT_LOAD_A,
                       3'($urandom), 3'($urandom), rand_elem());
        if ($urandom_range(3, 0) == 0)
            queue_xfer(ACT_SPARE, 3'($urandom), 3'($urandom), $urandom);
        load_missing_operands();
        queue_xfer(mm_pkg::ACT_START, 3'($urandom), 3'($urandom), $urandom);
        // Change one live operand and run again
        if (with_hold || $urandom_range(3, 0) == 0) begin
            queue_xfer(mm_pkg::ACT_LOAD_A, 3'($urandom_range(gen_m - 1, 0)),
                       3'($urandom_range(gen_r - 1, 0)), rand_elem());
            queue_xfer(mm_pkg::ACT_START, 3'($urandom), 3'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-element products: saturation both ways and flooring of a negative result
        set_dims(4'd1, 4'd1, 4'd1);
        queue_xfer(mm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        queue_xfer(mm_pkg::ACT_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        queue_xfer(mm_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
        queue_xfer(mm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        queue_xfer(mm_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
        queue_xfer(mm_pkg::ACT_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        queue_xfer(mm_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
        queue_xfer(mm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
        queue_xfer(mm_pkg::ACT_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        queue_xfer(mm_pkg::ACT_START, 3'd0, 3'd0, 32'h0);
        queue_xfer(ACT_SPARE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        queue_xfer(mm_pkg::ACT_START, 3'd7, 3'd7, 32'hFFFF_FFFF);

        // Zero rows and too many columns clamp to one row of eight
        set_dims(4'd0, 4'd1, 4'd15);
        write_reg(CFG_SPARE, 4'd15);
        load_missing_operands();
        queue_xfer(mm_pkg::ACT_LOAD_A, 3'd0, 3'd0, 32'h0001_0000);
        queue_xfer(mm_pkg::ACT_START, 3'd0, 3'd0, 32'h0);

        // Random runs, rotating through the idling patterns; a full-length inner sum
        // and a full 8 by 8 result come in on the way
        for (batch = 0; item_count < 100 || batch < 7; batch++) begin
            if (batch == 5)
                set_dims(4'd2, 4'd15, 4'd0);
            else if (batch == 6)
                set_dims(4'd15, 4'd1, 4'd8);
            else if (batch % 3 == 0)
                set_dims(rand_dim(), rand_dim(), rand_dim());
            case (batch % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            run_batch(batch == 4);
            while (pending_xfers.size() != 0)
                @(posedge i_clk);
        end

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_seq.sv
rtl/mm_mac.sv
rtl/matrix_multiply.sv
verif/matrix_multiply_test.sv
